// ----- rtl/pts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants of the point-to-segment projection pipeline.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned SEG_W      = 16;
  localparam int unsigned DIR_W      = 16;
  localparam int unsigned DIR_ONE    = 16384;
  localparam int unsigned T_BITS     = 30;
  localparam int unsigned DIR_Q_BITS = 15;
  localparam int unsigned NORM_MSB   = 19;
  localparam int unsigned SQ_IN_W    = 64;
  localparam int unsigned SQ_STEPS   = SQ_IN_W / 2;

endpackage

// ----- rtl/pts_delay.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_delay
// Fixed-depth payload delay line that advances with the pipeline enable.
// ----------------------------------------------------------------------------
module pts_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= d_i;
      for (int unsigned k = 1; k < DEPTH; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  assign q_o = line_q[DEPTH-1];

endmodule

// ----- rtl/pts_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_isqrt
// Pipelined integer square root, one result bit per stage, with remainder.
// ----------------------------------------------------------------------------
module pts_isqrt import pts_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [SQ_IN_W-1:0]  rad_i,
  output logic [SQ_STEPS-1:0] root_o,
  output logic [SQ_STEPS:0]   rem_o
);

  logic [SQ_IN_W-1:0] x_q [SQ_STEPS];
  logic [SQ_IN_W-1:0] r_q [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    localparam logic [SQ_IN_W-1:0] Bit = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * i);
    logic [SQ_IN_W-1:0] x_in;
    logic [SQ_IN_W-1:0] r_in;
    logic [SQ_IN_W-1:0] x_d;
    logic [SQ_IN_W-1:0] r_d;
    logic [SQ_IN_W:0]   trial;

    if (i == 0) begin : g_first
      assign x_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign r_in = r_q[i-1];
    end

    always_comb begin
      trial = {1'b0, r_in} + {1'b0, Bit};
      if ({1'b0, x_in} >= trial) begin
        x_d = x_in - trial[SQ_IN_W-1:0];
        r_d = (r_in >> 1) + Bit;
      end else begin
        x_d = x_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_d;
        r_q[i] <= r_d;
      end
    end
  end

  assign root_o = r_q[SQ_STEPS-1][SQ_STEPS-1:0];
  assign rem_o  = x_q[SQ_STEPS-1][SQ_STEPS:0];

endmodule

// ----- rtl/point_to_segment_projection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_segment_projection
// Projects a query point onto a 3D segment in the XZ plane: closest point,
// offset along the segment, unit heading and horizontal distance.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  in       | valid_i / ready_o | seg_id, a_xyz, b_xyz, seg_len, query_xz
//  out      | valid_o / ready_i | seg_out, along, near_xyz, dir_xyz, gap
//
//  One beat enters per cycle while the output is not stalled.
//  The result path is the 30-stage division for t followed by the 32-stage
//  square root for the distance; the heading path runs alongside it.
//  Reset clears only the stage valid bits.
//  A stall on the output freezes the whole pipeline; ready_o is high
//  whenever the output register is empty or being taken.
// ----------------------------------------------------------------------------
module point_to_segment_projection import pts_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [SEG_W-1:0]          seg_id_i,
  input  logic signed [COORD_W-1:0] a_x_i,
  input  logic signed [COORD_W-1:0] a_y_i,
  input  logic signed [COORD_W-1:0] a_z_i,
  input  logic signed [COORD_W-1:0] b_x_i,
  input  logic signed [COORD_W-1:0] b_y_i,
  input  logic signed [COORD_W-1:0] b_z_i,
  input  logic [COORD_W-1:0]        seg_len_i,
  input  logic signed [COORD_W-1:0] query_x_i,
  input  logic signed [COORD_W-1:0] query_z_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [SEG_W-1:0]          seg_out_o,
  output logic [COORD_W-1:0]        along_o,
  output logic signed [COORD_W-1:0] near_x_o,
  output logic signed [COORD_W-1:0] near_y_o,
  output logic signed [COORD_W-1:0] near_z_o,
  output logic signed [DIR_W-1:0]   dir_x_o,
  output logic signed [DIR_W-1:0]   dir_y_o,
  output logic signed [DIR_W-1:0]   dir_z_o,
  output logic [COORD_W-1:0]        gap_o
);

  localparam int unsigned DW       = COORD_W + 1;       // difference width
  localparam int unsigned PW       = 2 * DW;            // product width
  localparam int unsigned NW       = NORM_MSB + 1;      // normalized width
  localparam int unsigned TW       = T_BITS + 1;
  localparam int unsigned NumW     = NW + 25 + 2;
  localparam int unsigned LenW     = SQ_STEPS + 1;
  localparam int unsigned FrontLat = 5;
  localparam int unsigned TSel     = FrontLat + T_BITS + 1;
  localparam int unsigned GapIn    = TSel + 6;
  localparam int unsigned GapEnd   = GapIn + SQ_STEPS;
  localparam int unsigned Lat      = GapEnd + 1;
  localparam int unsigned HeadIn   = 6;
  localparam int unsigned HeadOut  = HeadIn + SQ_STEPS + 1 + DIR_Q_BITS + 1;
  localparam int unsigned HeadDly  = GapEnd - HeadOut;
  localparam logic [TW-1:0] TOne   = TW'(1) << T_BITS;
  localparam logic [63:0] RoundHalf = 64'(1) << (T_BITS - 1);

  typedef struct packed {
    logic [SEG_W-1:0]   seg;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] az;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qz;
    logic [COORD_W-1:0] len;
    logic [DW-1:0]      mdx;
    logic [DW-1:0]      mdy;
    logic [DW-1:0]      mdz;
    logic               sdx;
    logic               sdy;
    logic               sdz;
  } side_t;

  typedef struct packed {
    logic [SEG_W-1:0]   seg;
    logic [COORD_W-1:0] along;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [COORD_W-1:0] nz;
  } near_t;

  typedef struct packed {
    logic [2:0][NW-1:0] nm;
    logic [2:0]         sgn;
    logic               len0;
    logic               mzero;
  } hside_t;

  function automatic logic [DW-1:0] mag_f(input logic [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : v;
  endfunction

  function automatic logic [5:0] msb_f(input logic [DW-1:0] v);
    logic [5:0] p;
    p = '0;
    for (int k = 0; k < DW; k++) begin
      if (v[k]) p = 6'(k);
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // handshake and valid chain
  // --------------------------------------------------------------------------
  logic           adv;
  logic [Lat-1:0] vld_q;

  assign adv     = ready_i | ~valid_o;
  assign ready_o = adv;
  assign valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // front: differences and magnitudes
  // --------------------------------------------------------------------------
  logic [DW-1:0] dx_c, dy_c, dz_c, px_c, pz_c;
  side_t         side_c, side36;

  assign dx_c = {b_x_i[COORD_W-1], b_x_i} - {a_x_i[COORD_W-1], a_x_i};
  assign dy_c = {b_y_i[COORD_W-1], b_y_i} - {a_y_i[COORD_W-1], a_y_i};
  assign dz_c = {b_z_i[COORD_W-1], b_z_i} - {a_z_i[COORD_W-1], a_z_i};
  assign px_c = {query_x_i[COORD_W-1], query_x_i} - {a_x_i[COORD_W-1], a_x_i};
  assign pz_c = {query_z_i[COORD_W-1], query_z_i} - {a_z_i[COORD_W-1], a_z_i};

  always_comb begin
    side_c.seg = seg_id_i;
    side_c.ax  = a_x_i;
    side_c.ay  = a_y_i;
    side_c.az  = a_z_i;
    side_c.qx  = query_x_i;
    side_c.qz  = query_z_i;
    side_c.len = seg_len_i;
    side_c.mdx = mag_f(dx_c);
    side_c.mdy = mag_f(dy_c);
    side_c.mdz = mag_f(dz_c);
    side_c.sdx = dx_c[DW-1];
    side_c.sdy = dy_c[DW-1];
    side_c.sdz = dz_c[DW-1];
  end

  pts_delay #(.WIDTH($bits(side_t)), .DEPTH(TSel)) u_side_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (side_c),
    .q_o   (side36)
  );

  logic [DW-1:0] mdx_q, mdy_q, mdz_q, mpx_q, mpz_q;
  logic          sdx_q, sdy_q, sdz_q, dnx_q, dnz_q, len0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mdx_q  <= side_c.mdx;
      mdy_q  <= side_c.mdy;
      mdz_q  <= side_c.mdz;
      mpx_q  <= mag_f(px_c);
      mpz_q  <= mag_f(pz_c);
      sdx_q  <= dx_c[DW-1];
      sdy_q  <= dy_c[DW-1];
      sdz_q  <= dz_c[DW-1];
      dnx_q  <= px_c[DW-1] ^ dx_c[DW-1];
      dnz_q  <= pz_c[DW-1] ^ dz_c[DW-1];
      len0_q <= (seg_len_i == '0);
    end
  end

  // --------------------------------------------------------------------------
  // dot product and squared length, then setup of the division for t
  // --------------------------------------------------------------------------
  logic [PW-1:0] sqx_q, sqz_q, dotx_q, dotz_q;
  logic          dnx2_q, dnz2_q;
  logic [PW-1:0] len2_3_q, pos_q, neg_q;
  logic [PW-1:0] len2_4_q, rem4_q;
  logic          zero4_q;
  logic [PW-1:0] len2_5_q, rem5_q;
  logic          zero5_q, one5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q    <= mdx_q * mdx_q;
      sqz_q    <= mdz_q * mdz_q;
      dotx_q   <= mpx_q * mdx_q;
      dotz_q   <= mpz_q * mdz_q;
      dnx2_q   <= dnx_q;
      dnz2_q   <= dnz_q;
      len2_3_q <= sqx_q + sqz_q;
      pos_q    <= (dnx2_q ? '0 : dotx_q) + (dnz2_q ? '0 : dotz_q);
      neg_q    <= (dnx2_q ? dotx_q : '0) + (dnz2_q ? dotz_q : '0);
      len2_4_q <= len2_3_q;
      rem4_q   <= pos_q - neg_q;
      zero4_q  <= (len2_3_q == '0) || (neg_q >= pos_q);
      len2_5_q <= len2_4_q;
      rem5_q   <= rem4_q;
      zero5_q  <= zero4_q;
      one5_q   <= (rem4_q >= len2_4_q);
    end
  end

  // --------------------------------------------------------------------------
  // restoring division for t, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic [PW-1:0]     dv_rem_q  [T_BITS];
  logic [PW-1:0]     dv_len_q  [T_BITS];
  logic [T_BITS-1:0] dv_quo_q  [T_BITS];
  logic              dv_zero_q [T_BITS];
  logic              dv_one_q  [T_BITS];

  for (genvar j = 0; j < T_BITS; j++) begin : g_tdiv
    logic [PW-1:0]     rem_in, len_in, rem_d;
    logic [T_BITS-1:0] quo_in;
    logic              zero_in, one_in, qbit;
    logic [PW:0]       rem2;

    if (j == 0) begin : g_first
      assign rem_in  = rem5_q;
      assign len_in  = len2_5_q;
      assign quo_in  = '0;
      assign zero_in = zero5_q;
      assign one_in  = one5_q;
    end else begin : g_next
      assign rem_in  = dv_rem_q[j-1];
      assign len_in  = dv_len_q[j-1];
      assign quo_in  = dv_quo_q[j-1];
      assign zero_in = dv_zero_q[j-1];
      assign one_in  = dv_one_q[j-1];
    end

    always_comb begin
      rem2 = {rem_in, 1'b0};
      if (rem2 >= {1'b0, len_in}) begin
        rem_d = PW'(rem2 - {1'b0, len_in});
        qbit  = 1'b1;
      end else begin
        rem_d = rem2[PW-1:0];
        qbit  = 1'b0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[j]  <= rem_d;
        dv_len_q[j]  <= len_in;
        dv_quo_q[j]  <= {quo_in[T_BITS-2:0], qbit};
        dv_zero_q[j] <= zero_in;
        dv_one_q[j]  <= one_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // t select, interpolation, closest point and distance setup
  // --------------------------------------------------------------------------
  logic [TW-1:0]      t_q;
  logic [63:0]        pmx_q, pmy_q, pmz_q, pml_q;
  side_t              s37_q, s38_q;
  logic [63:0]        rx_w, ry_w, rz_w, rl_w;
  logic [DW:0]        rndx_q, rndy_q, rndz_q;
  logic [COORD_W-1:0] along38_q;
  logic [DW:0]        nx_w, ny_w, nz_w;
  near_t              n39_q, n40_q, n41_q, n42_q, n74;
  logic [COORD_W-1:0] qx39_q, qz39_q;
  logic [DW-1:0]      ex_w, ez_w;
  logic [DW-1:0]      emx_q, emz_q;
  logic [PW-1:0]      esx_q, esz_q;
  logic [PW-1:0]      s2_w;
  logic [SQ_IN_W-1:0] s2_q;
  logic               sat42_q, sat74;

  always_comb begin
    rx_w = pmx_q + RoundHalf;
    ry_w = pmy_q + RoundHalf;
    rz_w = pmz_q + RoundHalf;
    rl_w = pml_q + RoundHalf;
    nx_w = s38_q.sdx ? {{2{s38_q.ax[COORD_W-1]}}, s38_q.ax} - rndx_q
                     : {{2{s38_q.ax[COORD_W-1]}}, s38_q.ax} + rndx_q;
    ny_w = s38_q.sdy ? {{2{s38_q.ay[COORD_W-1]}}, s38_q.ay} - rndy_q
                     : {{2{s38_q.ay[COORD_W-1]}}, s38_q.ay} + rndy_q;
    nz_w = s38_q.sdz ? {{2{s38_q.az[COORD_W-1]}}, s38_q.az} - rndz_q
                     : {{2{s38_q.az[COORD_W-1]}}, s38_q.az} + rndz_q;
    ex_w = {qx39_q[COORD_W-1], qx39_q} - {n39_q.nx[COORD_W-1], n39_q.nx};
    ez_w = {qz39_q[COORD_W-1], qz39_q} - {n39_q.nz[COORD_W-1], n39_q.nz};
    s2_w = esx_q + esz_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (dv_zero_q[T_BITS-1]) begin
        t_q <= '0;
      end else if (dv_one_q[T_BITS-1]) begin
        t_q <= TOne;
      end else begin
        t_q <= {1'b0, dv_quo_q[T_BITS-1]};
      end
      pmx_q     <= side36.mdx * t_q;
      pmy_q     <= side36.mdy * t_q;
      pmz_q     <= side36.mdz * t_q;
      pml_q     <= 64'(side36.len) * 64'(t_q);
      s37_q     <= side36;
      rndx_q    <= rx_w[T_BITS +: DW+1];
      rndy_q    <= ry_w[T_BITS +: DW+1];
      rndz_q    <= rz_w[T_BITS +: DW+1];
      along38_q <= rl_w[T_BITS +: COORD_W];
      s38_q     <= s37_q;
      n39_q.seg   <= s38_q.seg;
      n39_q.along <= along38_q;
      n39_q.nx    <= nx_w[COORD_W-1:0];
      n39_q.ny    <= ny_w[COORD_W-1:0];
      n39_q.nz    <= nz_w[COORD_W-1:0];
      qx39_q    <= s38_q.qx;
      qz39_q    <= s38_q.qz;
      emx_q     <= mag_f(ex_w);
      emz_q     <= mag_f(ez_w);
      n40_q     <= n39_q;
      esx_q     <= emx_q * emx_q;
      esz_q     <= emz_q * emz_q;
      n41_q     <= n40_q;
      s2_q      <= s2_w[SQ_IN_W-1:0];
      sat42_q   <= (s2_w[PW-1:SQ_IN_W] != '0);
      n42_q     <= n41_q;
    end
  end

  logic [SQ_STEPS-1:0] groot;
  logic [SQ_STEPS:0]   grem;

  pts_isqrt u_gap_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (s2_q),
    .root_o (groot),
    .rem_o  (grem)
  );

  pts_delay #(.WIDTH($bits(near_t) + 1), .DEPTH(SQ_STEPS)) u_gap_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({n42_q, sat42_q}),
    .q_o   ({n74, sat74})
  );

  // --------------------------------------------------------------------------
  // heading: normalize, length by square root, three component divisions
  // --------------------------------------------------------------------------
  logic [2:0][DW-1:0] hm2_q;
  logic [DW-1:0]      mm2_q;
  logic [2:0]         hs2_q, hs3_q, hs4_q, hs5_q;
  logic               hl2_q, hl3_q, hl4_q, hl5_q, hz3_q, hz4_q, hz5_q;
  logic [2:0][DW-1:0] hm3_q;
  logic [5:0]         hp3_q;
  logic [2:0][DW-1:0] hsh_w;
  logic [2:0][NW-1:0] nm4_q, nm5_q;
  logic [2:0][2*NW-1:0] hsq5_q;
  logic [2*NW+1:0]    n2_6_q;
  hside_t             hs6_q, hs38;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (hp3_q > 6'(NORM_MSB)) begin
        hsh_w[k] = hm3_q[k] >> (hp3_q - 6'(NORM_MSB));
      end else begin
        hsh_w[k] = hm3_q[k] << (6'(NORM_MSB) - hp3_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hm2_q <= {mdz_q, mdy_q, mdx_q};
      mm2_q <= (mdx_q > mdy_q) ? ((mdz_q > mdx_q) ? mdz_q : mdx_q)
                               : ((mdz_q > mdy_q) ? mdz_q : mdy_q);
      hs2_q <= {sdz_q, sdy_q, sdx_q};
      hl2_q <= len0_q;
      hm3_q <= hm2_q;
      hp3_q <= msb_f(mm2_q);
      hz3_q <= (mm2_q == '0);
      hs3_q <= hs2_q;
      hl3_q <= hl2_q;
      for (int k = 0; k < 3; k++) begin
        nm4_q[k]  <= hsh_w[k][NW-1:0];
        hsq5_q[k] <= nm4_q[k] * nm4_q[k];
      end
      hs4_q  <= hs3_q;
      hl4_q  <= hl3_q;
      hz4_q  <= hz3_q;
      nm5_q  <= nm4_q;
      hs5_q  <= hs4_q;
      hl5_q  <= hl4_q;
      hz5_q  <= hz4_q;
      n2_6_q <= (2*NW+2)'(hsq5_q[0]) + (2*NW+2)'(hsq5_q[1]) + (2*NW+2)'(hsq5_q[2]);
      hs6_q.nm    <= nm5_q;
      hs6_q.sgn   <= hs5_q;
      hs6_q.len0  <= hl5_q;
      hs6_q.mzero <= hz5_q;
    end
  end

  logic [SQ_STEPS-1:0] hroot;
  logic [SQ_STEPS:0]   hrem_unused;

  // Radicand is the squared norm scaled by 2^20.
  pts_isqrt u_len_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (SQ_IN_W'({n2_6_q, 20'b0})),
    .root_o (hroot),
    .rem_o  (hrem_unused)
  );

  pts_delay #(.WIDTH($bits(hside_t)), .DEPTH(SQ_STEPS)) u_head_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (hs6_q),
    .q_o   (hs38)
  );

  logic [2:0][NumW-1:0] num39_q;
  logic [LenW-1:0]      dvs39_q;
  hside_t               hs39_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        num39_q[k] <= (NumW'(hs38.nm[k]) << 25) + NumW'(hroot);
      end
      dvs39_q <= {hroot, 1'b0};
      hs39_q  <= hs38;
    end
  end

  logic [2:0][NumW-1:0]       hd_rem_q [DIR_Q_BITS];
  logic [2:0][DIR_Q_BITS-1:0] hd_quo_q [DIR_Q_BITS];
  logic [LenW-1:0]            hd_dvs_q [DIR_Q_BITS];
  hside_t                     hd_side_q [DIR_Q_BITS];

  for (genvar j = 0; j < DIR_Q_BITS; j++) begin : g_hdiv
    localparam int unsigned Sh = DIR_Q_BITS - 1 - j;
    logic [2:0][NumW-1:0]       rem_in, rem_d;
    logic [2:0][DIR_Q_BITS-1:0] quo_in, quo_d;
    logic [LenW-1:0]            dvs_in;
    hside_t                     side_in;
    logic [NumW-1:0]            trial;

    if (j == 0) begin : g_first
      assign rem_in  = num39_q;
      assign quo_in  = '0;
      assign dvs_in  = dvs39_q;
      assign side_in = hs39_q;
    end else begin : g_next
      assign rem_in  = hd_rem_q[j-1];
      assign quo_in  = hd_quo_q[j-1];
      assign dvs_in  = hd_dvs_q[j-1];
      assign side_in = hd_side_q[j-1];
    end

    always_comb begin
      trial = NumW'(dvs_in) << Sh;
      for (int k = 0; k < 3; k++) begin
        if (rem_in[k] >= trial) begin
          rem_d[k] = rem_in[k] - trial;
          quo_d[k] = {quo_in[k][DIR_Q_BITS-2:0], 1'b1};
        end else begin
          rem_d[k] = rem_in[k];
          quo_d[k] = {quo_in[k][DIR_Q_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        hd_rem_q[j]  <= rem_d;
        hd_quo_q[j]  <= quo_d;
        hd_dvs_q[j]  <= dvs_in;
        hd_side_q[j] <= side_in;
      end
    end
  end

  logic [2:0][DIR_W-1:0] dir_w;
  logic [2:0][DIR_W-1:0] dir55_q, dir74;
  hside_t                hsl;

  assign hsl = hd_side_q[DIR_Q_BITS-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [DIR_W-1:0] qv;
      qv = DIR_W'(hd_quo_q[DIR_Q_BITS-1][k]);
      if (qv > DIR_W'(DIR_ONE)) qv = DIR_W'(DIR_ONE);
      dir_w[k] = hsl.sgn[k] ? DIR_W'(-qv) : qv;
      if (hsl.len0 || hsl.mzero) dir_w[k] = '0;
    end
    // zero length points straight down the negative Z axis
    if (hsl.len0) dir_w[2] = DIR_W'(-DIR_W'(DIR_ONE));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dir55_q <= dir_w;
    end
  end

  pts_delay #(.WIDTH(3 * DIR_W), .DEPTH(HeadDly)) u_dir_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (dir55_q),
    .q_o   (dir74)
  );

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  near_t              out_q;
  logic [2:0][DIR_W-1:0] dout_q;
  logic [COORD_W-1:0] gap_q, gap_d;

  always_comb begin
    if (sat74) begin
      gap_d = '1;
    end else if (grem > LenW'(groot) && groot != '1) begin
      gap_d = groot + 1'b1;
    end else begin
      gap_d = groot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q  <= n74;
      dout_q <= dir74;
      gap_q  <= gap_d;
    end
  end

  assign seg_out_o = out_q.seg;
  assign along_o   = out_q.along;
  assign near_x_o  = out_q.nx;
  assign near_y_o  = out_q.ny;
  assign near_z_o  = out_q.nz;
  assign dir_x_o   = dout_q[0];
  assign dir_y_o   = dout_q[1];
  assign dir_z_o   = dout_q[2];
  assign gap_o     = gap_q;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("stage valid bits moved during a stall");

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[TSel-1] |-> (t_q <= TOne))
    else $error("t above one");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($signed(dir_x_o) <= 16'sd16384 && $signed(dir_x_o) >= -16'sd16384 &&
                 $signed(dir_y_o) <= 16'sd16384 && $signed(dir_y_o) >= -16'sd16384 &&
                 $signed(dir_z_o) <= 16'sd16384 && $signed(dir_z_o) >= -16'sd16384))
    else $error("heading component out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(gap_o) && $stable(dir_z_o)))
    else $error("output beat changed while stalled");
`endif

endmodule
